// ===== sv/priority_csma_tx_scheduler_unit_assert.svh =====
// Assertion macros for the priority transmit scheduler.
`ifndef PRIORITY_CSMA_TX_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_CSMA_TX_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PCSMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCSMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pcsma_pkg.sv =====
// Shared types and constants for the priority transmit scheduler.
`timescale 1ns / 1ps
package pcsma_pkg;

  localparam int LANE_DEPTH_DEF      = 8;
  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int NUM_LANES_DEF       = 4;

  localparam int LEN_W = 9;
  localparam int DIV_W = 17;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_SEND = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_BAD_PRIO = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [2:0] REG_ENABLED     = 3'd0;
  localparam logic [2:0] REG_CCA_CAPABLE = 3'd1;
  localparam logic [2:0] REG_BUSY_RSSI   = 3'd2;
  localparam logic [2:0] REG_MAX_RETRIES = 3'd3;
  localparam logic [2:0] REG_BACKOFF_MAX = 3'd4;

  localparam logic [15:0] BUSY_RSSI_RST   = 16'hFFB0;
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;
  localparam logic [15:0] BACKOFF_MAX_RST = 16'd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_EVAL,
    S_MOD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0]      handle;
    logic [LEN_W-1:0] length;
    logic [31:0]      retry_time;
    logic [3:0]       attempts;
    logic [31:0]      enq_time;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      dividend;
    logic [DIV_W-1:0] divisor;
  } mod_req_t;

endpackage

// ===== sv/pcsma_mod_unit.sv =====
// Bit-serial remainder unit for the backoff draw.
`timescale 1ns / 1ps
module pcsma_mod_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  pcsma_pkg::mod_req_t     req,
  output logic                    done,
  output logic [pcsma_pkg::DIV_W-1:0] rem
);

  logic [31:0]                  quo;
  logic [pcsma_pkg::DIV_W-1:0]  div;
  logic [pcsma_pkg::DIV_W:0]    acc;
  logic [pcsma_pkg::DIV_W:0]    trial;
  logic [5:0]                   cnt;

  assign trial = {acc[pcsma_pkg::DIV_W-1:0], quo[31]};
  assign rem   = acc[pcsma_pkg::DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= 6'd32;
        quo <= req.dividend;
        div <= req.divisor;
        acc <= '0;
      end else if (cnt != 6'd0) begin
        acc <= (trial >= {1'b0, div}) ? trial - {1'b0, div} : trial;
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        done <= (cnt == 6'd1);
      end
    end
  end

endmodule

// ===== sv/priority_csma_tx_scheduler_unit.sv =====
// Top level of the priority transmit scheduler.
// Input channel (in_valid/in_stall) carries one word per operation: an
// enqueue (operation 0) or a transmit poll pass (operation 1). Each word
// yields exactly one result word on the output channel (out_valid/out_stall).
// A poll pass walks lanes from 0 upward, skipping empty ones and reading
// and evaluating each visited head; busy backoff awaits the serial remainder.
// A new word is taken only once the previous result sits in the output
// register, so one word is in work at a time.
// Descriptors live in one synchronous memory of NUM_LANES*LANE_DEPTH
// entries; lane head and fill count are flip-flops.
// Reset (rst, synchronous) empties every lane, clears out_valid and
// restores register defaults; no clearing pass is needed.
// While out_stall holds a result, the next word may finish its work but
// waits in the done state; in_stall stays high until the result moves.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle;
// the user is bound to this, as the block itself does not enforce it.
`timescale 1ns / 1ps
module priority_csma_tx_scheduler_unit #(
  parameter int LANE_DEPTH      = pcsma_pkg::LANE_DEPTH_DEF,
  parameter int MAX_FRAME_BYTES = pcsma_pkg::MAX_FRAME_BYTES_DEF,
  parameter int NUM_LANES       = pcsma_pkg::NUM_LANES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [2:0]                  priority_req,
  input  logic [15:0]                 frame_handle,
  input  logic [15:0]                 frame_length,
  input  logic [31:0]                 now_ms,
  input  logic signed [15:0]          rssi_dbm,
  input  logic                        rssi_valid,
  input  logic [31:0]                 random_lane0,
  input  logic [31:0]                 random_lane1,
  input  logic [31:0]                 random_lane2,
  input  logic [31:0]                 random_lane3,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  result_kind,
  output logic [2:0]                  status_code,
  output logic [1:0]                  sent_lane,
  output logic [15:0]                 sent_handle,
  output logic [pcsma_pkg::LEN_W-1:0] sent_length,
  output logic [3:0]                  sent_attempts,
  output logic [31:0]                 queue_delay_ms
);

  localparam int LW    = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int LCW   = $clog2(NUM_LANES + 1);
  localparam int HW    = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam int CW    = $clog2(LANE_DEPTH + 1);
  localparam int SLOTS = NUM_LANES * LANE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // configuration
  logic               enabled;
  logic               cca_capable;
  logic signed [15:0] busy_rssi;
  logic [3:0]         max_retries;
  logic [15:0]        backoff_max;

  // captured item
  logic [2:0]         prio_q;
  logic [15:0]        handle_q;
  logic [15:0]        length_q;
  logic [31:0]        now_q;
  logic               busy_q;
  logic [31:0]        rnd_q [4];

  pcsma_pkg::state_t state, state_next;

  logic [HW-1:0]  lane_head  [NUM_LANES];
  logic [CW-1:0]  lane_count [NUM_LANES];
  logic [LCW-1:0] lane_idx;

  pcsma_pkg::entry_t mem [SLOTS];
  pcsma_pkg::entry_t rd_q;
  pcsma_pkg::entry_t wr_data;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              rd_en, wr_en;

  // result staging
  logic [1:0]                  res_kind;
  logic [2:0]                  res_status;
  logic [1:0]                  res_lane;
  logic [15:0]                 res_handle;
  logic [pcsma_pkg::LEN_W-1:0] res_length;
  logic [3:0]                  res_attempts;
  logic [31:0]                 res_delay;

  pcsma_pkg::mod_req_t         mod_req;
  logic                        mod_done;
  logic [pcsma_pkg::DIV_W-1:0] mod_rem;

  logic              accept;
  logic              out_free;
  logic [LW-1:0]     cl;
  logic [HW-1:0]     head_c, head_inc;
  logic [CW-1:0]     cnt_c;
  logic [CW:0]       tail_sum;
  logic [HW-1:0]     tail_pos;
  logic              lanes_done;
  logic              ready;
  logic              retry;
  logic [2:0]        enq_status;
  logic              do_pop, do_requeue, do_push, do_next_lane, do_emit;

  assign in_stall = (state != pcsma_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign cl       = (state == pcsma_pkg::S_ENQ) ? prio_q[LW-1:0] : lane_idx[LW-1:0];
  assign head_c   = lane_head[cl];
  assign cnt_c    = lane_count[cl];
  assign tail_sum = (CW+1)'(head_c) + (CW+1)'(cnt_c);
  assign tail_pos = (tail_sum >= (CW+1)'(LANE_DEPTH)) ?
                    HW'(tail_sum - (CW+1)'(LANE_DEPTH)) : HW'(tail_sum);
  assign head_inc = (head_c == HW'(LANE_DEPTH - 1)) ? '0 : head_c + HW'(1);
  assign lanes_done = (lane_idx == LCW'(NUM_LANES));

  assign ready = (rd_q.retry_time == 32'd0) || (now_q >= rd_q.retry_time);
  assign retry = (rd_q.attempts < max_retries) && busy_q;

  always_comb begin
    if (!enabled) begin
      enq_status = pcsma_pkg::ST_DISABLED;
    end else if (32'(length_q) > MAX_FRAME_BYTES) begin
      enq_status = pcsma_pkg::ST_TOO_LONG;
    end else if (32'(prio_q) >= NUM_LANES) begin
      enq_status = pcsma_pkg::ST_BAD_PRIO;
    end else if (32'(cnt_c) >= LANE_DEPTH) begin
      enq_status = pcsma_pkg::ST_FULL;
    end else begin
      enq_status = pcsma_pkg::ST_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pcsma_pkg::S_IDLE: begin
        if (accept) begin
          if (!operation) state_next = pcsma_pkg::S_ENQ;
          else if (enabled) state_next = pcsma_pkg::S_SCAN;
          else state_next = pcsma_pkg::S_DONE;
        end
      end
      pcsma_pkg::S_ENQ: state_next = pcsma_pkg::S_DONE;
      pcsma_pkg::S_SCAN: begin
        if (lanes_done) state_next = pcsma_pkg::S_DONE;
        else if (cnt_c != '0) state_next = pcsma_pkg::S_EVAL;
      end
      pcsma_pkg::S_EVAL: begin
        if (!ready) state_next = pcsma_pkg::S_SCAN;
        else if (retry) state_next = pcsma_pkg::S_MOD;
        else state_next = pcsma_pkg::S_DONE;
      end
      pcsma_pkg::S_MOD: begin
        if (mod_done) state_next = pcsma_pkg::S_SCAN;
      end
      pcsma_pkg::S_DONE: begin
        if (out_free) state_next = pcsma_pkg::S_IDLE;
      end
      default: state_next = pcsma_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_data      = rd_q;
    do_pop       = 1'b0;
    do_requeue   = 1'b0;
    do_push      = 1'b0;
    do_next_lane = 1'b0;
    do_emit      = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = rnd_q[lane_idx[1:0]];
    mod_req.divisor  = {1'b0, backoff_max} + pcsma_pkg::DIV_W'(1);
    unique case (state)
      pcsma_pkg::S_ENQ: begin
        if (enq_status == pcsma_pkg::ST_OK) begin
          wr_en   = 1'b1;
          do_push = 1'b1;
          wr_data.handle     = handle_q;
          wr_data.length     = length_q[pcsma_pkg::LEN_W-1:0];
          wr_data.retry_time = '0;
          wr_data.attempts   = '0;
          wr_data.enq_time   = now_q;
        end
      end
      pcsma_pkg::S_SCAN: begin
        rd_en = !lanes_done && (cnt_c != '0);
        do_next_lane = !lanes_done && (cnt_c == '0);
      end
      pcsma_pkg::S_EVAL: begin
        if (!ready) begin
          wr_en        = 1'b1;
          do_requeue   = 1'b1;
          do_next_lane = 1'b1;
        end else if (retry) begin
          mod_req.start = 1'b1;
        end else begin
          do_pop  = 1'b1;
          do_emit = 1'b1;
        end
      end
      pcsma_pkg::S_MOD: begin
        if (mod_done) begin
          wr_en        = 1'b1;
          do_requeue   = 1'b1;
          do_next_lane = 1'b1;
          wr_data.attempts   = rd_q.attempts + 4'd1;
          wr_data.retry_time = now_q + 32'(mod_rem);
        end
      end
      default: ;
    endcase
  end

  assign rd_addr = AW'(int'(cl) * LANE_DEPTH + int'(head_c));
  assign wr_addr = AW'(int'(cl) * LANE_DEPTH + int'(tail_pos));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  pcsma_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .done (mod_done),
    .rem  (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      cca_capable <= 1'b0;
      busy_rssi   <= pcsma_pkg::BUSY_RSSI_RST;
      max_retries <= pcsma_pkg::MAX_RETRIES_RST;
      backoff_max <= pcsma_pkg::BACKOFF_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcsma_pkg::REG_ENABLED:     enabled     <= cfg_data[0];
        pcsma_pkg::REG_CCA_CAPABLE: cca_capable <= cfg_data[0];
        pcsma_pkg::REG_BUSY_RSSI:   busy_rssi   <= cfg_data;
        pcsma_pkg::REG_MAX_RETRIES: max_retries <= cfg_data[3:0];
        pcsma_pkg::REG_BACKOFF_MAX: backoff_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pcsma_pkg::S_IDLE;
      lane_idx <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_head[i]  <= '0;
        lane_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) lane_idx <= '0;
      else if (do_next_lane) lane_idx <= lane_idx + LCW'(1);
      if (do_push) lane_count[cl] <= cnt_c + CW'(1);
      if (do_pop) lane_count[cl] <= cnt_c - CW'(1);
      if (do_pop || do_requeue) lane_head[cl] <= head_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prio_q   <= priority_req;
      handle_q <= frame_handle;
      length_q <= frame_length;
      now_q    <= now_ms;
      busy_q   <= cca_capable && rssi_valid && (rssi_dbm >= busy_rssi);
      rnd_q[0] <= random_lane0;
      rnd_q[1] <= random_lane1;
      rnd_q[2] <= random_lane2;
      rnd_q[3] <= random_lane3;
      res_kind     <= operation ? pcsma_pkg::KIND_NONE : pcsma_pkg::KIND_ENQ;
      res_status   <= pcsma_pkg::ST_OK;
      res_lane     <= '0;
      res_handle   <= '0;
      res_length   <= '0;
      res_attempts <= '0;
      res_delay    <= '0;
    end else if (state == pcsma_pkg::S_ENQ) begin
      res_status <= enq_status;
    end else if (do_emit) begin
      res_kind     <= pcsma_pkg::KIND_SEND;
      res_lane     <= lane_idx[1:0];
      res_handle   <= rd_q.handle;
      res_length   <= rd_q.length;
      res_attempts <= rd_q.attempts;
      res_delay    <= now_q - rd_q.enq_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pcsma_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcsma_pkg::S_DONE && out_free) begin
      result_kind    <= res_kind;
      status_code    <= res_status;
      sent_lane      <= res_lane;
      sent_handle    <= res_handle;
      sent_length    <= res_length;
      sent_attempts  <= res_attempts;
      queue_delay_ms <= res_delay;
    end
  end

endmodule

// ===== sv/pcsma_checker.sv =====
// Port-level checker for the priority transmit scheduler, with its bind.
`timescale 1ns / 1ps
`include "priority_csma_tx_scheduler_unit_assert.svh"
module pcsma_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [2:0]  status_code,
  input logic [15:0] sent_handle,
  input logic [8:0]  sent_length,
  input logic [3:0]  sent_attempts,
  input logic [31:0] queue_delay_ms
);

  `PCSMA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
  `PCSMA_ASSERT_NOW(a_enq_clean, out_valid && result_kind == pcsma_pkg::KIND_ENQ, sent_handle == 16'd0 && queue_delay_ms == 32'd0, "enqueue status carries frame data")
  `PCSMA_ASSERT_NOW(a_send_ok, out_valid && result_kind == pcsma_pkg::KIND_SEND, status_code == pcsma_pkg::ST_OK, "sent frame with nonzero status")
  `PCSMA_ASSERT_NOW(a_none_clean, out_valid && result_kind == pcsma_pkg::KIND_NONE, sent_length == 9'd0 && sent_attempts == 4'd0 && status_code == pcsma_pkg::ST_OK, "idle pass carries data")

endmodule

bind priority_csma_tx_scheduler_unit pcsma_checker u_pcsma_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .result_kind    (result_kind),
  .status_code    (status_code),
  .sent_handle    (sent_handle),
  .sent_length    (sent_length),
  .sent_attempts  (sent_attempts),
  .queue_delay_ms (queue_delay_ms)
);
